>>> hw/rtl/sht_pkg.sv
// ----------------------------------------------------------------------------
// sht_pkg
// types and constants shared by the sparse histogram table
// ----------------------------------------------------------------------------
`default_nettype none
package sht_pkg;

    localparam int unsigned SHT_CAPACITY       = 256;
    localparam int unsigned SHT_DIMENSIONS     = 8;
    localparam int unsigned SHT_BIN_INDEX_BITS = 6;
    localparam int unsigned KEY_W              = 48;
    localparam int unsigned VAL_W              = 32;

    localparam logic [2:0] K_LOOKUP  = 3'd0;
    localparam logic [2:0] K_PUT     = 3'd1;
    localparam logic [2:0] K_ADD     = 3'd2;
    localparam logic [2:0] K_REMOVE  = 3'd3;
    localparam logic [2:0] K_MUL     = 3'd4;
    localparam logic [2:0] K_DIV     = 3'd5;
    localparam logic [2:0] K_DIV_ALL = 3'd6;
    localparam logic [2:0] K_CLEAR   = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    typedef struct packed {
        logic [2:0]        kind;
        logic [KEY_W-1:0]  bin_key;
        logic signed [VAL_W-1:0] operand;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] bin_value;
        logic                    found;
        logic [1:0]              status;
    } t_out_item;

endpackage
`default_nettype wire

>>> hw/rtl/sht_ram.sv
// ----------------------------------------------------------------------------
// sht_ram
// generic simple dual port ram (separate write and read address), one write and one registered read a cycle
// ----------------------------------------------------------------------------
`default_nettype none
module sht_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/sparse_histogram_table_unit.sv
// ----------------------------------------------------------------------------
// sparse_histogram_table_unit
// bounded key/value table of Q16.16 histogram bins with keyed updates
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in      | input     | i_valid / o_ready  | i_item  (kind, bin_key, operand)
// out     | output    | o_valid / i_ready  | o_item  (bin_value, found, status)
//
// keyed items sweep every slot, one slot a cycle through the key/count rams,
//   to find the match and the lowest free slot, then pass a read state and
//   a compute state; a lookup then waits in the output register until taken
// put adds a write back state; add and multiply on a hit add a stage and a write back
// divide is a 48 bit restoring divider plus a rounding step
// divide all walks the table again, each valid entry through the divider
// valid bits are flip-flops cleared by reset and by clear all; no ram sweep
// one item at a time; the result waits in an output register under stall
// ----------------------------------------------------------------------------
`default_nettype none
module sparse_histogram_table_unit
    import sht_pkg::*;
#(
    parameter int unsigned CAPACITY       = SHT_CAPACITY,
    parameter int unsigned DIMENSIONS     = SHT_DIMENSIONS,
    parameter int unsigned BIN_INDEX_BITS = SHT_BIN_INDEX_BITS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_item
);
    localparam int unsigned AW    = $clog2(CAPACITY);
    localparam int unsigned CW    = AW + 1;
    localparam int unsigned KBITS = (DIMENSIONS * BIN_INDEX_BITS >= KEY_W) ? KEY_W
                                    : DIMENSIONS * BIN_INDEX_BITS;
    localparam logic [KEY_W-1:0] KMASK = (KBITS >= KEY_W) ? {KEY_W{1'b1}}
                                    : ((KEY_W'(1) << KBITS) - KEY_W'(1));
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // state codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;  // search for key and free slot
    localparam logic [3:0] S_RD    = 4'd2;  // read count of hit slot
    localparam logic [3:0] S_OP    = 4'd3;  // compute
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_WB    = 4'd6;
    localparam logic [3:0] S_ARD   = 4'd7;  // divide all: issue read
    localparam logic [3:0] S_AWT   = 4'd8;  // divide all: data back
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]          r_st;
    t_in_item            r_in;
    logic [CAPACITY-1:0] r_vld;
    logic [CW-1:0]       r_idx;      // scan/issue index
    logic                r_pend;     // read in flight last cycle
    logic [AW-1:0]       r_pidx;     // index of read in flight
    logic                r_hit, r_free_ok;
    logic [AW-1:0]       r_hit_i, r_free_i;
    logic signed [VAL_W-1:0] r_cnt;
    logic signed [VAL_W-1:0] r_res;
    logic                r_sat;
    logic [1:0]          r_status;
    logic [AW-1:0]       r_wi;       // write back slot
    logic                r_all;      // divider serving divide all
    logic signed [63:0]  r_prod;
    // divider
    logic [48:0]         r_rem;
    logic [47:0]         r_quo;
    logic [47:0]         r_num;
    logic [31:0]         r_den;
    logic [5:0]          r_dcnt;
    logic                r_neg;

    logic [KEY_W-1:0]    key_m;
    logic [KEY_W-1:0]    k_rdata;
    logic [VAL_W-1:0]    c_rdata;
    logic                k_we, c_we;
    logic [AW-1:0]       k_waddr, c_waddr, raddr;
    logic [VAL_W-1:0]    c_wdata;

    assign key_m = r_in.bin_key & KMASK;

    sht_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
        .i_clk(i_clk), .i_we(k_we), .i_waddr(k_waddr), .i_wdata(key_m),
        .i_raddr(raddr), .o_rdata(k_rdata));
    sht_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_cnt_ram (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(raddr), .o_rdata(c_rdata));

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);

    // read address: scan index, or hit slot
    always_comb begin
        raddr = r_idx[AW-1:0];
        if (r_st == S_RD) begin
            raddr = r_hit_i;
        end
    end

    // saturate 64 bit to 32
    function automatic logic [32:0] sat64(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > 64'sd2147483647)       r = {1'b1, 32'h7fffffff};
        else if (v < -64'sd2147483648) r = {1'b1, 32'h80000000};
        else                           r = {1'b0, v[31:0]};
        return r;
    endfunction

    logic signed [63:0] sum64;
    logic [32:0]        sat_sum, sat_mul, sat_div;
    logic signed [63:0] qs;
    logic [48:0]        trial;
    assign sum64   = 64'(r_cnt) + 64'(r_in.operand);
    assign sat_sum = sat64(sum64);
    assign sat_mul = sat64(r_prod >>> 16);
    // signed quotient from the rounded magnitude and the sign of the operands
    assign qs      = r_neg ? -$signed({16'd0, r_quo}) : $signed({16'd0, r_quo});
    assign sat_div = sat64(qs);
    assign trial   = {r_rem[47:0], r_num[47]} - {17'd0, r_den};

    // writes
    always_comb begin
        k_we    = (r_st == S_WB) && !r_hit && (r_in.kind == K_PUT || r_in.kind == K_ADD);
        k_waddr = r_wi;
        c_we    = (r_st == S_WB) && (r_in.kind != K_REMOVE);
        c_waddr = r_wi;
        c_wdata = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_vld <= '0;
            r_pend <= 1'b0;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in      <= i_item;
                        r_idx     <= '0;
                        r_pend    <= 1'b0;
                        r_hit     <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_sat     <= 1'b0;
                        r_status  <= ST_OK;
                        r_st      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend <= (r_idx != CAP_C);
                    r_pidx <= r_idx[AW-1:0];
                    if (r_idx != CAP_C) begin
                        r_idx <= r_idx + CW'(1);
                        if (!r_vld[r_idx[AW-1:0]] && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free_i  <= r_idx[AW-1:0];
                        end
                    end
                    if (r_pend && r_vld[r_pidx] && k_rdata == key_m) begin
                        r_hit   <= 1'b1;
                        r_hit_i <= r_pidx;
                    end
                    if (r_idx == CAP_C && !r_pend) begin
                        r_st <= S_RD;
                    end
                end
                S_RD: begin
                    r_st <= S_OP;
                end
                S_OP: begin
                    r_cnt  <= r_hit ? $signed(c_rdata) : '0;
                    r_wi   <= r_hit ? r_hit_i : r_free_i;
                    r_res  <= r_hit ? $signed(c_rdata) : '0;
                    r_prod <= 64'(signed'(c_rdata)) * 64'(r_in.operand) + 64'sd32768;
                    r_all  <= 1'b0;
                    r_st   <= S_OUT;
                    unique case (r_in.kind)
                        K_PUT, K_ADD: begin
                            if (!r_hit && !r_free_ok) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_st <= S_WB;
                                if (!r_hit || r_in.kind == K_PUT) begin
                                    r_res <= r_in.operand;
                                end else begin
                                    r_cnt <= $signed(c_rdata);
                                    r_st  <= S_MUL; // reuse as add stage
                                end
                            end
                        end
                        K_REMOVE: begin
                            if (r_hit) begin
                                r_vld[r_hit_i] <= 1'b0;
                            end
                            r_res <= '0;
                        end
                        K_MUL: begin
                            if (r_hit) r_st <= S_MUL;
                        end
                        K_DIV, K_DIV_ALL: begin
                            if (r_in.operand == '0) begin
                                r_status <= ST_DIV0;
                            end else if (r_in.kind == K_DIV_ALL) begin
                                r_all <= 1'b1;
                                r_idx <= '0;
                                r_st  <= S_ARD;
                            end else if (r_hit) begin
                                r_st <= S_DIV;
                                r_dcnt <= 6'd0;
                                r_num  <= {(c_rdata[31] ? -c_rdata : c_rdata), 16'd0};
                                r_rem  <= '0;
                                r_quo  <= '0;
                                r_den  <= r_in.operand[31] ? -r_in.operand : r_in.operand;
                                r_neg  <= c_rdata[31] ^ r_in.operand[31];
                            end
                        end
                        K_CLEAR: begin
                            r_vld <= '0;
                            r_res <= '0;
                        end
                        default: begin
                        end
                    endcase
                end
                S_MUL: begin
                    if (r_in.kind == K_ADD) begin
                        r_res <= sat_sum[31:0];
                        r_sat <= sat_sum[32];
                        r_st  <= S_WB;
                    end else begin
                        r_res <= sat_mul[31:0];
                        r_sat <= sat_mul[32];
                        r_st  <= S_WB;
                    end
                end
                S_DIV: begin
                    // restoring step over 48 numerator bits, then a round bit
                    if (r_dcnt == 6'd49) begin
                        r_res <= sat_div[31:0];
                        if (sat_div[32]) r_sat <= 1'b1;
                        r_st  <= S_WB;
                    end else if (r_dcnt == 6'd48) begin
                        // round half away: rem*2 >= den
                        r_dcnt <= r_dcnt + 6'd1;
                        r_quo  <= r_quo + (({r_rem, 1'b0} >= 50'(r_den)) ? 48'd1 : 48'd0);
                    end else begin
                        r_dcnt <= r_dcnt + 6'd1;
                        r_num  <= {r_num[46:0], 1'b0};
                        if (!trial[48]) begin
                            r_rem <= trial;
                            r_quo <= {r_quo[46:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[47:0], r_num[47]};
                            r_quo <= {r_quo[46:0], 1'b0};
                        end
                    end
                end
                S_WB: begin
                    if ((r_in.kind == K_PUT || r_in.kind == K_ADD) && !r_hit) begin
                        r_vld[r_wi] <= 1'b1;
                    end
                    if (r_all) begin
                        if (r_wi == r_hit_i && r_hit) r_cnt <= r_res;
                        r_idx <= {1'b0, r_wi} + CW'(1);
                        r_st  <= S_ARD;
                    end else begin
                        r_st <= S_OUT;
                    end
                end
                S_ARD: begin
                    if (r_idx == CAP_C) begin
                        r_res <= r_hit ? r_cnt : '0;
                        r_st  <= S_OUT;
                    end else if (r_vld[r_idx[AW-1:0]]) begin
                        r_wi <= r_idx[AW-1:0];
                        r_st <= S_AWT;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_AWT: begin
                    r_dcnt <= 6'd0;
                    r_num  <= {(c_rdata[31] ? -c_rdata : c_rdata), 16'd0};
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_den  <= r_in.operand[31] ? -r_in.operand : r_in.operand;
                    r_neg  <= c_rdata[31] ^ r_in.operand[31];
                    r_st   <= S_DIV;
                end
                S_OUT: begin
                    if (r_sat && r_status == ST_OK) r_status <= ST_SAT;
                    if (i_ready) r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_item.bin_value = (r_in.kind == K_REMOVE || r_in.kind == K_CLEAR ||
                            r_status == ST_FULL) ? '0 :
                           ((r_hit || r_in.kind == K_PUT || r_in.kind == K_ADD) ? r_res : '0);
        o_item.found     = r_hit;
        o_item.status    = (r_sat && r_status == ST_OK) ? ST_SAT : r_status;
    end

    // assertions
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_st == S_SCAN)) else $error("item not taken");
endmodule
`default_nettype wire
